// ===== hdl/decimal_rpm_lcd_writer_top_assert.svh =====
// Assertion macros for the decimal RPM LCD writer.
// Used by drlw_seq, which checks its own control logic.
`ifndef DECIMAL_RPM_LCD_WRITER_TOP_ASSERT_SVH
`define DECIMAL_RPM_LCD_WRITER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DRLW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DRLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DRLW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DRLW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/drlw_pkg.sv =====
// Package for the decimal RPM LCD writer: widths, LCD codes, sequencer states
// and the request/response structs between the converter and the sequencer.
// No dependencies.
package drlw_pkg;

	localparam int SPEED_W    = 15;
	localparam int MAX_DIGITS = 5;
	localparam int BCD_W      = 4 * MAX_DIGITS;

	localparam logic [7:0] CMD_CLEAR = 8'h01;
	localparam logic [7:0] CMD_HOME  = 8'h80;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_R     = 8'h52;
	localparam logic [7:0] CHR_P     = 8'h50;
	localparam logic [7:0] CHR_M     = 8'h4D;

	function automatic logic [63:0] dec_limit(input int digits);
		logic [63:0] acc;
		acc = 64'd1;
		for (int i = 0; i < digits; i++) begin
			acc = acc * 64'd10;
		end
		return acc;
	endfunction

	localparam logic [63:0] SAT_MAX = dec_limit(MAX_DIGITS) - 64'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_CLEAR,
		ST_HOME,
		ST_DIGIT,
		ST_SPACE,
		ST_R,
		ST_P,
		ST_M
	} drlw_state_t;

	typedef struct packed {
		logic               start;
		logic [SPEED_W-1:0] value;
	} conv_req_t;

	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} conv_rsp_t;

endpackage

// ===== hdl/drlw_in_if.sv =====
// Input channel: one speed value per word, valid/ready handshake.
// Depends on drlw_pkg.
interface drlw_in_if;
	import drlw_pkg::*;

	logic               valid;
	logic               ready;
	logic [SPEED_W-1:0] speed_value;

	modport source (output valid, output speed_value, input ready);
	modport sink (input valid, input speed_value, output ready);
endinterface

// ===== hdl/drlw_out_if.sv =====
// Output channel: one LCD write per word, valid/ready handshake.
// No dependencies.
interface drlw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] lcd_byte;
	logic       register_select;
	logic       last_write;

	modport source (output valid, output lcd_byte, output register_select,
		output last_write, input ready);
	modport sink (input valid, input lcd_byte, input register_select,
		input last_write, output ready);
endinterface

// ===== hdl/drlw_bcd_conv.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on drlw_pkg.
module drlw_bcd_conv (
	input  logic                clk,
	input  logic                arst_n,
	input  drlw_pkg::conv_req_t req,
	output drlw_pkg::conv_rsp_t rsp
);
	import drlw_pkg::*;

	localparam int CNT_W = $clog2(SPEED_W + 1);

	logic [SPEED_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;
	logic [SPEED_W-1:0] sat_val;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_comb begin
		if ({{(64 - SPEED_W){1'b0}}, req.value} > SAT_MAX)
			sat_val = SAT_MAX[SPEED_W-1:0];
		else
			sat_val = req.value;
	end

	always_comb begin
		logic [3:0] dig;
		for (int d = 0; d < MAX_DIGITS; d++) begin
			dig = bcd_q[4*d +: 4];
			adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SPEED_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			bin_q <= sat_val;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[SPEED_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[SPEED_W-1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.bcd  = bcd_q;

endmodule

// ===== hdl/drlw_seq.sv =====
// Write sequencer: issues clear, home, the digits with leading zeros dropped,
// then " RPM", through a registered output slot. Depends on drlw_pkg,
// drlw_in_if, drlw_out_if and the assertion header.
`include "decimal_rpm_lcd_writer_top_assert.svh"

module drlw_seq (
	input  logic                clk,
	input  logic                arst_n,
	drlw_in_if.sink             in_ch,
	drlw_out_if.source          out_ch,
	output drlw_pkg::conv_req_t req,
	input  drlw_pkg::conv_rsp_t rsp
);
	import drlw_pkg::*;

	localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

	drlw_state_t       state_q, state_n;
	logic [BCD_W-1:0]  dig_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              lead_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              rs_q;
	logic              last_q;

	logic       adv;
	logic       accept;
	logic [3:0] top_dig;
	logic       skip;
	logic       emit_c;
	logic [7:0] byte_c;
	logic       rs_c;
	logic       last_c;
	logic       step;

	assign adv     = !out_valid_q || out_ch.ready;
	assign accept  = in_ch.valid && in_ch.ready;
	assign top_dig = dig_q[BCD_W-1 -: 4];
	assign skip    = lead_q && (top_dig == 4'd0) && (dcnt_q != DCNT_W'(1));
	assign step    = skip || adv;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign req.start   = accept;
	assign req.value   = in_ch.speed_value;

	always_comb begin
		emit_c = 1'b0;
		byte_c = CHR_SPACE;
		rs_c   = 1'b1;
		last_c = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				emit_c = 1'b1;
				byte_c = CMD_CLEAR;
				rs_c   = 1'b0;
			end
			ST_HOME: begin
				emit_c = 1'b1;
				byte_c = CMD_HOME;
				rs_c   = 1'b0;
			end
			ST_DIGIT: begin
				emit_c = !skip;
				byte_c = CHR_ZERO | {4'd0, top_dig};
			end
			ST_SPACE: begin
				emit_c = 1'b1;
				byte_c = CHR_SPACE;
			end
			ST_R: begin
				emit_c = 1'b1;
				byte_c = CHR_R;
			end
			ST_P: begin
				emit_c = 1'b1;
				byte_c = CHR_P;
			end
			ST_M: begin
				emit_c = 1'b1;
				byte_c = CHR_M;
				last_c = 1'b1;
			end
			default: begin
				emit_c = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_n = ST_CONV;
			ST_CONV:  if (rsp.done) state_n = ST_CLEAR;
			ST_CLEAR: if (adv) state_n = ST_HOME;
			ST_HOME:  if (adv) state_n = ST_DIGIT;
			ST_DIGIT: if (step && dcnt_q == DCNT_W'(1)) state_n = ST_SPACE;
			ST_SPACE: if (adv) state_n = ST_R;
			ST_R:     if (adv) state_n = ST_P;
			ST_P:     if (adv) state_n = ST_M;
			ST_M:     if (adv) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dcnt_q      <= '0;
			lead_q      <= 1'b0;
		end else begin
			state_q <= state_n;
			if (adv)
				out_valid_q <= emit_c;
			if (state_q == ST_CONV && rsp.done) begin
				dcnt_q <= DCNT_W'(MAX_DIGITS);
				lead_q <= 1'b1;
			end else if (state_q == ST_DIGIT && step) begin
				dcnt_q <= dcnt_q - DCNT_W'(1);
				if (!skip)
					lead_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CONV && rsp.done)
			dig_q <= rsp.bcd;
		else if (state_q == ST_DIGIT && step)
			dig_q <= {dig_q[BCD_W-5:0], 4'd0};
		if (adv && emit_c) begin
			byte_q <= byte_c;
			rs_q   <= rs_c;
			last_q <= last_c;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.lcd_byte        = byte_q;
	assign out_ch.register_select = rs_q;
	assign out_ch.last_write      = last_q;

	`DRLW_ASSERT_NEXT(a_accept_conv, clk, arst_n, accept, state_q == ST_CONV, "accept did not start conversion")
	`DRLW_ASSERT_IMPL(a_done_in_conv, clk, arst_n, rsp.done, state_q == ST_CONV, "conversion done outside conversion wait")
	`DRLW_ASSERT_IMPL(a_digit_cnt, clk, arst_n, state_q == ST_DIGIT, dcnt_q != '0, "digit state with no digits left")
	`DRLW_ASSERT_IMPL(a_last_is_m, clk, arst_n, out_valid_q && last_q, byte_q == CHR_M && rs_q, "last word is not the final character")

endmodule

// ===== hdl/decimal_rpm_lcd_writer_top.sv =====
// Decimal RPM LCD writer, top level.
// Depends on drlw_pkg, drlw_in_if, drlw_out_if, drlw_bcd_conv and drlw_seq.
//
// Usage:
//   in_ch carries one 15-bit speed value per word. in_ch.ready is high only
//   while the block is idle; one value is taken at a time.
//   out_ch carries the LCD writes for that value, 7 to 11 words: clear and
//   cursor home with register_select low, then the decimal digits with
//   leading zeros dropped (zero shows as a single '0'), a space and "RPM"
//   with register_select high. last_write marks the 'M'.
// Conversion and sequencing:
//   The converter shifts one input bit per cycle; the first write is offered
//   once the conversion is done and the sequencer has loaded the clear
//   command into the output register. The sequencer then works through the
//   writes and the dropped leading zeros in order, and in_ch.ready returns
//   only once the 'M' is in the output register.
// Reset and stalls:
//   arst_n clears the sequencer and the output slot at once; nothing is
//   pending after reset. When out_ch.ready is low the current word holds in
//   the output register and the sequence waits; no word is lost or repeated.
module decimal_rpm_lcd_writer_top (
	input  logic       clk,
	input  logic       arst_n,
	drlw_in_if.sink    in_ch,
	drlw_out_if.source out_ch
);
	import drlw_pkg::*;

	conv_req_t conv_req;
	conv_rsp_t conv_rsp;

	drlw_bcd_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (conv_req),
		.rsp    (conv_rsp)
	);

	drlw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.req    (conv_req),
		.rsp    (conv_rsp)
	);

endmodule
